// ===== design/dqne_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor package
// Shared constants, command and status types, and the walker state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package dqne_pkg;

    // Default sizes of the packet buffer and run limits.
    localparam int PACKET_BYTES_DEF = 512;
    localparam int CHASE_LIMIT_DEF  = 16;
    localparam int RESULT_LIMIT_DEF = 64;

    // Walk addresses hold a 14-bit pointer plus one and the largest skip past the buffer.
    localparam int ADDR_W = 16;

    localparam logic [ADDR_W-1:0] HEADER_BYTES       = 16'd12;
    localparam logic [ADDR_W-1:0] SKIP_AFTER_ZERO    = 16'd5;
    localparam logic [ADDR_W-1:0] SKIP_AFTER_POINTER = 16'd6;
    localparam logic [1:0]        POINTER_TAG        = 2'b11;

    // Command queue between the front and the walker; depth is a power of two.
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // Input mode codes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_CHASE = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_TRUNC = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_EXTRACT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [15:0] count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NAME_RD,
        ST_NAME_CHK,
        ST_PTR_HI,
        ST_PTR_LO,
        ST_PTR_TGT,
        ST_PTR_CHK,
        ST_COPY_RD,
        ST_COPY_CHK,
        ST_STOP,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== design/dqne_front.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor front end
// Accepts input items, decodes the mode and queues a command for the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_front
(
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire logic [1:0]           mode,
    input  wire logic [7:0]           data_byte,
    input  wire logic [15:0]          question_count,
    input  wire dqne_pkg::q_status_t  q_status,
    output logic                      push,
    output dqne_pkg::cmd_t            push_cmd
);

    logic known_mode;

    // The unused mode is taken and dropped without a command.
    always_comb
    begin
        known_mode        = 1'b1;
        push_cmd.op       = dqne_pkg::OP_LOAD;
        push_cmd.data     = data_byte;
        push_cmd.count    = question_count;
        unique case (mode)
            dqne_pkg::MODE_LOAD:    push_cmd.op = dqne_pkg::OP_LOAD;
            dqne_pkg::MODE_EXTRACT: push_cmd.op = dqne_pkg::OP_EXTRACT;
            dqne_pkg::MODE_CLEAR:   push_cmd.op = dqne_pkg::OP_CLEAR;
            default:                known_mode  = 1'b0;
        endcase
    end

    assign cmd_stall = q_status.full;
    assign push      = cmd_valid && !q_status.full && known_mode;

endmodule

`default_nettype wire

// ===== design/dqne_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor command queue
// A short queue that decouples the front end from the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_cmd_fifo
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dqne_pkg::cmd_t      push_cmd,
    input  wire logic                pop,
    output dqne_pkg::cmd_t           pop_cmd,
    output dqne_pkg::q_status_t      q_status
);

    localparam int PW = dqne_pkg::CMD_PTR_W;
    localparam int FW = dqne_pkg::CMD_PTR_W + 1;

    dqne_pkg::cmd_t  entry_reg [dqne_pkg::CMD_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (fill_reg == FW'(dqne_pkg::CMD_DEPTH));
    assign q_status.empty = (fill_reg == '0);

endmodule

`default_nettype wire

// ===== design/dqne_walker.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor walker
// Owns the packet buffer, runs the question walk and packs the name bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_walker
#(
    parameter int PACKET_BYTES = dqne_pkg::PACKET_BYTES_DEF,
    parameter int CHASE_LIMIT  = dqne_pkg::CHASE_LIMIT_DEF,
    parameter int RESULT_LIMIT = dqne_pkg::RESULT_LIMIT_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dqne_pkg::q_status_t  q_status,
    input  wire dqne_pkg::cmd_t       pop_cmd,
    output logic                      pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [63:0]               name_bytes,
    output logic [3:0]                byte_count,
    output logic [15:0]               question_index,
    output logic                      end_of_name,
    output logic                      last,
    output logic [1:0]                error
);

    localparam int MAW = $clog2(PACKET_BYTES);
    localparam int LW  = $clog2(PACKET_BYTES + 1);
    localparam int CW  = $clog2(CHASE_LIMIT + 1);
    localparam int RW  = $clog2(RESULT_LIMIT + 1);
    localparam int AW  = dqne_pkg::ADDR_W;

    // Packet buffer with one write port and one registered read port.
    logic [7:0]        mem [PACKET_BYTES];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    dqne_pkg::state_t  state_reg;
    dqne_pkg::state_t  state_next;
    logic [LW-1:0]     load_len_reg;
    logic [LW-1:0]     load_len_next;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [7:0]        hi_reg;
    logic [7:0]        hi_next;
    logic [CW-1:0]     follows_reg;
    logic [CW-1:0]     follows_next;
    logic [15:0]       q_reg;
    logic [15:0]       q_next;
    logic [15:0]       count_reg;
    logic [15:0]       count_next;
    logic [63:0]       pack_reg;
    logic [63:0]       pack_next;
    logic [3:0]        pack_cnt_reg;
    logic [3:0]        pack_cnt_next;
    logic [RW-1:0]     res_n_reg;
    logic [RW-1:0]     res_n_next;
    dqne_pkg::err_t    err_reg;
    dqne_pkg::err_t    err_next;

    // Held-back result: it learns whether it is the final one only later.
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [63:0]       pend_bytes_reg;
    logic [63:0]       pend_bytes_next;
    logic [3:0]        pend_cnt_reg;
    logic [3:0]        pend_cnt_next;
    logic [15:0]       pend_q_reg;
    logic [15:0]       pend_q_next;
    logic              pend_eon_reg;
    logic              pend_eon_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       out_bytes_reg;
    logic [63:0]       out_bytes_next;
    logic [3:0]        out_cnt_reg;
    logic [3:0]        out_cnt_next;
    logic [15:0]       out_q_reg;
    logic [15:0]       out_q_next;
    logic              out_eon_reg;
    logic              out_eon_next;
    logic              out_last_reg;
    logic              out_last_next;
    dqne_pkg::err_t    out_err_reg;
    dqne_pkg::err_t    out_err_next;

    logic [AW-1:0]     load_len_ext;
    logic [AW-1:0]     addr_p1;
    logic [AW-1:0]     ptr_tgt;
    logic              rd_is_ptr;
    logic              rd_is_zero;
    logic              push_req;
    logic              emit_req;
    logic              emit_full;
    logic              out_free;
    logic              pend_block;
    logic              push_block;
    logic              push_trunc;
    logic              last_q;
    logic              do_push;
    logic [63:0]       pushed_pack;
    logic [3:0]        pushed_cnt;
    logic              emit_now;
    logic [63:0]       emit_bytes;
    logic [3:0]        emit_cnt;
    logic              emit_eon;
    logic              final_now;
    logic              out_load;

    assign load_len_ext = AW'(load_len_reg);
    assign addr_p1      = addr_reg + 1'b1;
    assign ptr_tgt      = AW'({hi_reg[5:0], rd_data_reg});
    assign rd_is_ptr    = (rd_data_reg[7:6] == dqne_pkg::POINTER_TAG);
    assign rd_is_zero   = (rd_data_reg == 8'd0);
    assign push_req     = ((state_reg == dqne_pkg::ST_NAME_CHK) && !rd_is_ptr)
                       || (state_reg == dqne_pkg::ST_COPY_CHK);
    assign emit_req     = push_req && (rd_is_zero || (pack_cnt_reg == 4'd7));
    assign emit_full    = (res_n_reg == RW'(RESULT_LIMIT));
    assign out_free     = !out_valid_reg || !res_stall;
    assign pend_block   = pend_valid_reg && !out_free;
    assign push_block   = emit_req && !emit_full && pend_block;
    assign push_trunc   = emit_req && emit_full;
    assign last_q       = (({1'b0, q_reg} + 17'd1) == {1'b0, count_reg});

    always_comb
    begin
        state_next      = state_reg;
        load_len_next   = load_len_reg;
        pos_next        = pos_reg;
        addr_next       = addr_reg;
        hi_next         = hi_reg;
        follows_next    = follows_reg;
        q_next          = q_reg;
        count_next      = count_reg;
        pack_next       = pack_reg;
        pack_cnt_next   = pack_cnt_reg;
        res_n_next      = res_n_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_q_next     = pend_q_reg;
        pend_eon_next   = pend_eon_reg;
        out_bytes_next  = out_bytes_reg;
        out_cnt_next    = out_cnt_reg;
        out_q_next      = out_q_reg;
        out_eon_next    = out_eon_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;
        out_load        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        pop             = 1'b0;
        do_push         = 1'b0;
        pushed_pack     = pack_reg;
        pushed_cnt      = pack_cnt_reg;
        emit_now        = 1'b0;
        emit_bytes      = pack_reg;
        emit_cnt        = pack_cnt_reg;
        emit_eon        = 1'b0;
        final_now       = 1'b0;

        unique case (state_reg)
            dqne_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    unique case (pop_cmd.op)
                        dqne_pkg::OP_LOAD:
                        begin
                            if (load_len_reg < LW'(PACKET_BYTES))
                            begin
                                wr_en         = 1'b1;
                                load_len_next = load_len_reg + 1'b1;
                            end
                        end
                        dqne_pkg::OP_CLEAR:
                        begin
                            load_len_next = '0;
                        end
                        dqne_pkg::OP_EXTRACT:
                        begin
                            pos_next        = dqne_pkg::HEADER_BYTES;
                            q_next          = '0;
                            count_next      = pop_cmd.count;
                            err_next        = dqne_pkg::ERR_NONE;
                            res_n_next      = '0;
                            pack_next       = '0;
                            pack_cnt_next   = '0;
                            pend_valid_next = 1'b0;
                            if (pop_cmd.count == 16'd0)
                            begin
                                state_next = dqne_pkg::ST_FINISH;
                            end
                            else
                            begin
                                state_next = dqne_pkg::ST_NAME_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dqne_pkg::ST_NAME_RD:
            begin
                if (pos_reg < load_len_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg;
                    state_next = dqne_pkg::ST_NAME_CHK;
                end
                else
                begin
                    err_next   = dqne_pkg::ERR_RANGE;
                    state_next = dqne_pkg::ST_STOP;
                end
            end
            dqne_pkg::ST_NAME_CHK:
            begin
                if (rd_is_ptr)
                begin
                    addr_next    = pos_reg;
                    follows_next = '0;
                    state_next   = dqne_pkg::ST_PTR_HI;
                end
                else if (push_trunc)
                begin
                    err_next   = dqne_pkg::ERR_TRUNC;
                    state_next = dqne_pkg::ST_FINISH;
                end
                else if (!push_block)
                begin
                    do_push = 1'b1;
                    if (rd_is_zero)
                    begin
                        pos_next = pos_reg + dqne_pkg::SKIP_AFTER_ZERO;
                        if (last_q)
                        begin
                            state_next = dqne_pkg::ST_FINISH;
                        end
                        else
                        begin
                            q_next     = q_reg + 1'b1;
                            state_next = dqne_pkg::ST_NAME_RD;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = dqne_pkg::ST_NAME_RD;
                    end
                end
            end
            dqne_pkg::ST_PTR_HI:
            begin
                if (follows_reg >= CW'(CHASE_LIMIT))
                begin
                    err_next   = dqne_pkg::ERR_CHASE;
                    state_next = dqne_pkg::ST_STOP;
                end
                else if (addr_reg < load_len_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg;
                    state_next = dqne_pkg::ST_PTR_LO;
                end
                else
                begin
                    err_next   = dqne_pkg::ERR_RANGE;
                    state_next = dqne_pkg::ST_STOP;
                end
            end
            dqne_pkg::ST_PTR_LO:
            begin
                hi_next = rd_data_reg;
                if (addr_p1 < load_len_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_p1;
                    state_next = dqne_pkg::ST_PTR_TGT;
                end
                else
                begin
                    err_next   = dqne_pkg::ERR_RANGE;
                    state_next = dqne_pkg::ST_STOP;
                end
            end
            dqne_pkg::ST_PTR_TGT:
            begin
                addr_next    = ptr_tgt;
                follows_next = follows_reg + 1'b1;
                if (ptr_tgt < load_len_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_tgt;
                    state_next = dqne_pkg::ST_PTR_CHK;
                end
                else
                begin
                    err_next   = dqne_pkg::ERR_RANGE;
                    state_next = dqne_pkg::ST_STOP;
                end
            end
            dqne_pkg::ST_PTR_CHK:
            begin
                if (rd_is_ptr)
                begin
                    state_next = dqne_pkg::ST_PTR_HI;
                end
                else
                begin
                    state_next = dqne_pkg::ST_COPY_CHK;
                end
            end
            dqne_pkg::ST_COPY_RD:
            begin
                if (addr_reg < load_len_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_reg;
                    state_next = dqne_pkg::ST_COPY_CHK;
                end
                else
                begin
                    err_next   = dqne_pkg::ERR_RANGE;
                    state_next = dqne_pkg::ST_STOP;
                end
            end
            dqne_pkg::ST_COPY_CHK:
            begin
                if (push_trunc)
                begin
                    err_next   = dqne_pkg::ERR_TRUNC;
                    state_next = dqne_pkg::ST_FINISH;
                end
                else if (!push_block)
                begin
                    do_push = 1'b1;
                    if (rd_is_zero)
                    begin
                        pos_next = pos_reg + dqne_pkg::SKIP_AFTER_POINTER;
                        if (last_q)
                        begin
                            state_next = dqne_pkg::ST_FINISH;
                        end
                        else
                        begin
                            q_next     = q_reg + 1'b1;
                            state_next = dqne_pkg::ST_NAME_RD;
                        end
                    end
                    else
                    begin
                        addr_next  = addr_p1;
                        state_next = dqne_pkg::ST_COPY_RD;
                    end
                end
            end
            dqne_pkg::ST_STOP:
            begin
                // A run stopped by an error flushes its partly filled result unless the result limit is reached.
                if ((pack_cnt_reg != 4'd0) && !emit_full)
                begin
                    if (!pend_block)
                    begin
                        emit_now   = 1'b1;
                        state_next = dqne_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    state_next = dqne_pkg::ST_FINISH;
                end
            end
            dqne_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    final_now     = 1'b1;
                    pack_next     = '0;
                    pack_cnt_next = '0;
                    state_next    = dqne_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dqne_pkg::ST_IDLE;
            end
        endcase

        // Byte packing, first byte in the top lane.
        if (do_push)
        begin
            pushed_pack[{3'd7 - pack_cnt_reg[2:0], 3'b000} +: 8] = rd_data_reg;
            pushed_cnt = pack_cnt_reg + 1'b1;
            if (emit_req)
            begin
                emit_now   = 1'b1;
                emit_bytes = pushed_pack;
                emit_cnt   = pushed_cnt;
                emit_eon   = rd_is_zero;
            end
            else
            begin
                pack_next     = pushed_pack;
                pack_cnt_next = pushed_cnt;
            end
        end

        // A new result replaces the held one, which moves to the output register.
        if (emit_now)
        begin
            if (pend_valid_reg)
            begin
                out_load       = 1'b1;
                out_bytes_next = pend_bytes_reg;
                out_cnt_next   = pend_cnt_reg;
                out_q_next     = pend_q_reg;
                out_eon_next   = pend_eon_reg;
                out_last_next  = 1'b0;
                out_err_next   = dqne_pkg::ERR_NONE;
            end
            pend_valid_next = 1'b1;
            pend_bytes_next = emit_bytes;
            pend_cnt_next   = emit_cnt;
            pend_q_next     = q_reg;
            pend_eon_next   = emit_eon;
            res_n_next      = res_n_reg + 1'b1;
            pack_next       = '0;
            pack_cnt_next   = '0;
        end

        // The final result is the held one, or an empty one if the run gave none.
        if (final_now)
        begin
            out_load = 1'b1;
            if (pend_valid_reg)
            begin
                out_bytes_next = pend_bytes_reg;
                out_cnt_next   = pend_cnt_reg;
                out_q_next     = pend_q_reg;
                out_eon_next   = pend_eon_reg;
            end
            else
            begin
                out_bytes_next = '0;
                out_cnt_next   = '0;
                out_q_next     = '0;
                out_eon_next   = 1'b0;
            end
            out_last_next   = 1'b1;
            out_err_next    = err_reg;
            pend_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dqne_pkg::ST_IDLE;
            load_len_reg   <= '0;
            pack_reg       <= '0;
            pack_cnt_reg   <= '0;
            res_n_reg      <= '0;
            err_reg        <= dqne_pkg::ERR_NONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_len_reg   <= load_len_next;
            pack_reg       <= pack_next;
            pack_cnt_reg   <= pack_cnt_next;
            res_n_reg      <= res_n_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        addr_reg       <= addr_next;
        hi_reg         <= hi_next;
        follows_reg    <= follows_next;
        q_reg          <= q_next;
        count_reg      <= count_next;
        pend_bytes_reg <= pend_bytes_next;
        pend_cnt_reg   <= pend_cnt_next;
        pend_q_reg     <= pend_q_next;
        pend_eon_reg   <= pend_eon_next;
        out_bytes_reg  <= out_bytes_next;
        out_cnt_reg    <= out_cnt_next;
        out_q_reg      <= out_q_next;
        out_eon_reg    <= out_eon_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[load_len_reg[MAW-1:0]] <= pop_cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[MAW-1:0]];
        end
    end

    assign res_valid      = out_valid_reg;
    assign name_bytes     = out_bytes_reg;
    assign byte_count     = out_cnt_reg;
    assign question_index = out_q_reg;
    assign end_of_name    = out_eon_reg;
    assign last           = out_last_reg;
    assign error          = out_err_reg;

endmodule

`default_nettype wire

// ===== design/dns_question_name_extractor_core.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor
// Loads a DNS packet byte by byte and extracts its question names, following
// compression pointers, as packed eight-byte result items.
// ----------------------------------------------------------------------------
// A load or clear item is handled by the walker straight from its idle state,
// and an unused-mode item is dropped by the front without reaching the walker,
// so packet bytes can be streamed in at one item per cycle while no run is in
// progress. An extract item starts a run that walks the packet buffer from
// offset 12. The buffer has a single read port with a registered output, and
// the walker issues one read and examines its data in the next cycle. Each
// pointer hop reads the high byte, the low byte and the target byte and then
// checks the target. A run ends by handing over the final result, which waits
// while the result side stalls. Items that arrive during a run wait in a
// two-entry command queue; input stall rises once that queue is full. Results
// are held back by one so that the final one can carry the last flag and the
// error code, and then pass through an output register, so the walker keeps
// working while a finished result waits to be taken, until it has another
// result to hand over. The packet buffer holds no valid bits: a read of a
// byte at or beyond the load length stops the run.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_question_name_extractor_core
#(
    parameter int PACKET_BYTES = dqne_pkg::PACKET_BYTES_DEF,
    parameter int CHASE_LIMIT  = dqne_pkg::CHASE_LIMIT_DEF,
    parameter int RESULT_LIMIT = dqne_pkg::RESULT_LIMIT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Command side.
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] question_count,

    // Result side.
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [63:0]      name_bytes,
    output logic [3:0]       byte_count,
    output logic [15:0]      question_index,
    output logic             end_of_name,
    output logic             last,
    output logic [1:0]       error
);

    dqne_pkg::q_status_t q_status;
    dqne_pkg::cmd_t      push_cmd;
    dqne_pkg::cmd_t      pop_cmd;
    logic                push;
    logic                pop;

    // The front decodes each item into a command and stalls on a full queue.
    dqne_front u_front
    (
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .mode           (mode),
        .data_byte      (data_byte),
        .question_count (question_count),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // The queue lets the front keep taking items while a run is in progress.
    dqne_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // The walker owns the packet buffer and produces the result items.
    dqne_walker
    #(
        .PACKET_BYTES (PACKET_BYTES),
        .CHASE_LIMIT  (CHASE_LIMIT),
        .RESULT_LIMIT (RESULT_LIMIT)
    )
    u_walker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .name_bytes     (name_bytes),
        .byte_count     (byte_count),
        .question_index (question_index),
        .end_of_name    (end_of_name),
        .last           (last),
        .error          (error)
    );

endmodule

`default_nettype wire

// ===== design/dqne_checker.sv =====
// ----------------------------------------------------------------------------
// DNS question name extractor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqne_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [63:0] name_bytes,
    input wire logic [3:0]  byte_count,
    input wire logic        end_of_name,
    input wire logic        last,
    input wire logic [1:0]  error
);

    // A stalled result stays in place.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(name_bytes)
            && $stable(byte_count) && $stable(last))
        else $error("stalled result changed");

    // Only a name end or the final result may leave partly filled.
    a_full_pack: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !end_of_name && !last |-> byte_count == 4'd8)
        else $error("partial result in the middle of a name");

    // A name end always carries at least its zero byte.
    a_eon_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && end_of_name |-> byte_count != 4'd0)
        else $error("name end without bytes");

    // Errors are only reported on the final result of a run.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (error != dqne_pkg::ERR_NONE) |-> last)
        else $error("error code on a result that is not final");

endmodule

bind dns_question_name_extractor_core dqne_checker u_dqne_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .name_bytes  (name_bytes),
    .byte_count  (byte_count),
    .end_of_name (end_of_name),
    .last        (last),
    .error       (error)
);

`default_nettype wire
